@@ src/dmic_pkg.sv @@
package dmic_pkg;

    // Field widths of the stream payloads.
    localparam int FIELD_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 2 * FIELD_W;
    localparam int OUT_TDATA_W = 4 * FIELD_W;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_FILL   = 1'b1
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT       = 2'd0,
        ST_MISS      = 2'd1,
        ST_FILL_DONE = 2'd2,
        ST_BUSY      = 2'd3
    } t_status;

endpackage

@@ src/direct_mapped_icache_fill_core.sv @@
// Channel   Dir  tdata                                      tuser
// s_axis    in   [31:0] address, [63:32] fill_data          [0] opcode
// m_axis    out  [31:0] read_data, [63:32] fill_address,    [1:0] status
//                [95:64] hit_count, [127:96] miss_count
//
// An item is registered at its transfer, and the tag and data memories are read at the
// same edge. When it leaves the input register the tag compare and all state updates take place
// and any result is registered, so the block takes one item per cycle while the output does not stall.
// After reset the tag memory is swept clear, one line a cycle, over all
// 2**LINE_INDEX_BITS lines; s_axis_tready stays low during the sweep.
// A result that waits on m_axis_tready holds one item in the input register and then stalls input.
module direct_mapped_icache_fill_core #(
    parameter int LINE_INDEX_BITS  = 6,
    parameter int WORD_OFFSET_BITS = 2,
    parameter int DATA_WIDTH       = 32,
    parameter int ADDRESS_WIDTH    = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [31:0] address, [63:32] fill_data
    input  logic [dmic_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] opcode
    input  logic [0:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [31:0] read_data, [63:32] fill_address, [95:64] hit_count, [127:96] miss_count
    output logic [dmic_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [1:0] status
    output logic [dmic_pkg::STATUS_W-1:0]    m_axis_tuser
);
    import dmic_pkg::*;

    localparam int NUM_LINES = 1 << LINE_INDEX_BITS;
    localparam int WORDS     = 1 << WORD_OFFSET_BITS;
    localparam int NUM_WORDS = NUM_LINES * WORDS;
    localparam int WA_W      = LINE_INDEX_BITS + WORD_OFFSET_BITS;
    localparam int OFF_W     = (WORD_OFFSET_BITS > 0) ? WORD_OFFSET_BITS : 1;
    localparam int TAG_SHIFT = LINE_INDEX_BITS + WORD_OFFSET_BITS;
    localparam int TAG_RAW   = ADDRESS_WIDTH - TAG_SHIFT;
    localparam int TAG_W     = (TAG_RAW > 0) ? TAG_RAW : 1;

    localparam logic [ADDRESS_WIDTH-1:0]   OFF_MASK = ADDRESS_WIDTH'(WORDS - 1);
    localparam logic [OFF_W-1:0]           LAST_POS = OFF_W'(WORDS - 1);
    localparam logic [LINE_INDEX_BITS-1:0] LAST_LINE = LINE_INDEX_BITS'(NUM_LINES - 1);
    localparam logic [FIELD_W-1:0]         CNT_MAX = '1;

    // Tag memory entries carry the valid bit above the tag.
    logic [TAG_W:0]            tag_mem [NUM_LINES];
    logic [DATA_WIDTH-1:0]     word_mem [NUM_WORDS];

    // Input decode.
    logic [ADDRESS_WIDTH-1:0]   in_addr;
    logic [LINE_INDEX_BITS-1:0] in_line;
    logic [OFF_W-1:0]           in_word;
    logic [TAG_W-1:0]           in_tag;
    logic [WA_W-1:0]            in_waddr;
    logic                       in_fire;

    // Input register.
    logic                       r_s1_valid;
    t_opcode                    r_s1_op;
    logic [LINE_INDEX_BITS-1:0] r_s1_line;
    logic [OFF_W-1:0]           r_s1_word;
    logic [TAG_W-1:0]           r_s1_tag;
    logic [ADDRESS_WIDTH-1:0]   r_s1_faddr;
    logic [DATA_WIDTH-1:0]      r_s1_fdata;

    // Memory read data and same-edge write bypass.
    logic [TAG_W:0]             r_tag_rd;
    logic [DATA_WIDTH-1:0]      r_word_rd;
    logic                       r_byp_tag;
    logic [TAG_W:0]             r_byp_tag_data;
    logic                       r_byp_word;
    logic [DATA_WIDTH-1:0]      r_byp_word_data;

    // Cache control state.
    logic                       r_clr_active;
    logic [LINE_INDEX_BITS-1:0] r_clr_idx;
    logic                       r_busy, n_busy;
    logic [OFF_W-1:0]           r_fill_pos, n_fill_pos;
    logic [LINE_INDEX_BITS-1:0] r_pend_line, n_pend_line;
    logic [TAG_W-1:0]           r_pend_tag, n_pend_tag;
    logic [OFF_W-1:0]           r_pend_word, n_pend_word;
    logic [DATA_WIDTH-1:0]      r_pend_data, n_pend_data;
    logic [FIELD_W-1:0]         r_hits, n_hits;
    logic [FIELD_W-1:0]         r_misses, n_misses;

    // Output register.
    logic                       r_out_valid;
    t_status                    r_out_status, n_out_status;
    logic [FIELD_W-1:0]         r_out_data, n_out_data;
    logic [FIELD_W-1:0]         r_out_faddr, n_out_faddr;
    logic [FIELD_W-1:0]         r_out_hits;
    logic [FIELD_W-1:0]         r_out_misses;

    logic                       s1_fire;
    logic                       out_load;
    logic                       lk_hit;
    logic [TAG_W:0]             lk_tag;
    logic [DATA_WIDTH-1:0]      lk_word;
    logic                       word_wr;
    logic [WA_W-1:0]            word_wr_addr;
    logic                       tag_wr;

    assign in_addr  = s_axis_tdata[ADDRESS_WIDTH-1:0];
    assign in_line  = LINE_INDEX_BITS'(in_addr >> WORD_OFFSET_BITS);
    assign in_word  = OFF_W'(in_addr & OFF_MASK);
    assign in_tag   = TAG_W'(in_addr >> TAG_SHIFT);
    assign in_waddr = (WA_W'(in_line) << WORD_OFFSET_BITS) | WA_W'(in_word);

    assign s1_fire       = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_clr_active && (!r_s1_valid || s1_fire);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign word_wr_addr = (WA_W'(r_pend_line) << WORD_OFFSET_BITS) | WA_W'(r_fill_pos);

    assign lk_tag  = r_byp_tag ? r_byp_tag_data : r_tag_rd;
    assign lk_word = r_byp_word ? r_byp_word_data : r_word_rd;
    assign lk_hit  = lk_tag[TAG_W] && (lk_tag[TAG_W-1:0] == r_s1_tag);

    always_comb begin
        n_busy       = r_busy;
        n_fill_pos   = r_fill_pos;
        n_pend_line  = r_pend_line;
        n_pend_tag   = r_pend_tag;
        n_pend_word  = r_pend_word;
        n_pend_data  = r_pend_data;
        n_hits       = r_hits;
        n_misses     = r_misses;
        n_out_status = ST_HIT;
        n_out_data   = '0;
        n_out_faddr  = '0;
        out_load     = 1'b0;
        word_wr      = 1'b0;
        tag_wr       = 1'b0;
        if (s1_fire) begin
            case (r_s1_op)
                OP_LOOKUP: begin
                    out_load = 1'b1;
                    if (r_busy) begin
                        n_out_status = ST_BUSY;
                    end else if (lk_hit) begin
                        n_out_status = ST_HIT;
                        n_out_data   = FIELD_W'(lk_word);
                        if (r_hits != CNT_MAX) begin
                            n_hits = r_hits + 1'b1;
                        end
                    end else begin
                        n_out_status = ST_MISS;
                        n_out_faddr  = FIELD_W'(r_s1_faddr);
                        n_busy       = 1'b1;
                        n_fill_pos   = '0;
                        n_pend_line  = r_s1_line;
                        n_pend_tag   = r_s1_tag;
                        n_pend_word  = r_s1_word;
                        if (r_misses != CNT_MAX) begin
                            n_misses = r_misses + 1'b1;
                        end
                    end
                end
                OP_FILL: begin
                    // A refill word with no miss outstanding is dropped.
                    if (r_busy) begin
                        word_wr = 1'b1;
                        if (r_fill_pos == r_pend_word) begin
                            n_pend_data = r_s1_fdata;
                        end
                        if (r_fill_pos == LAST_POS) begin
                            tag_wr       = 1'b1;
                            n_busy       = 1'b0;
                            n_fill_pos   = '0;
                            out_load     = 1'b1;
                            n_out_status = ST_FILL_DONE;
                            n_out_data   = (r_fill_pos == r_pend_word)
                                           ? FIELD_W'(r_s1_fdata) : FIELD_W'(r_pend_data);
                        end else begin
                            n_fill_pos = r_fill_pos + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Memories: read at input transfer, written as the item ahead is processed or by the clear sweep.
    always_ff @(posedge i_clk) begin
        if (r_clr_active) begin
            tag_mem[r_clr_idx] <= '0;
        end else if (tag_wr) begin
            tag_mem[r_pend_line] <= {1'b1, r_pend_tag};
        end
        if (in_fire) begin
            r_tag_rd <= tag_mem[in_line];
        end
    end

    always_ff @(posedge i_clk) begin
        if (word_wr) begin
            word_mem[word_wr_addr] <= r_s1_fdata;
        end
        if (in_fire) begin
            r_word_rd <= word_mem[in_waddr];
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_op         <= t_opcode'(s_axis_tuser[0]);
            r_s1_line       <= in_line;
            r_s1_word       <= in_word;
            r_s1_tag        <= in_tag;
            r_s1_faddr      <= in_addr & ~OFF_MASK;
            r_s1_fdata      <= DATA_WIDTH'(s_axis_tdata[IN_TDATA_W-1:FIELD_W]);
            // The read above misses a write made at this same edge, so keep that write.
            r_byp_tag       <= tag_wr && (r_pend_line == in_line);
            r_byp_tag_data  <= {1'b1, r_pend_tag};
            r_byp_word      <= word_wr && (word_wr_addr == in_waddr);
            r_byp_word_data <= r_s1_fdata;
        end
        if (out_load) begin
            r_out_status <= n_out_status;
            r_out_data   <= n_out_data;
            r_out_faddr  <= n_out_faddr;
            r_out_hits   <= n_hits;
            r_out_misses <= n_misses;
        end
        r_pend_line <= n_pend_line;
        r_pend_tag  <= n_pend_tag;
        r_pend_word <= n_pend_word;
        r_pend_data <= n_pend_data;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_clr_active <= 1'b1;
            r_clr_idx    <= '0;
            r_busy       <= 1'b0;
            r_fill_pos   <= '0;
            r_hits       <= '0;
            r_misses     <= '0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (r_clr_active) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == LAST_LINE) begin
                    r_clr_active <= 1'b0;
                end
            end
            r_busy     <= n_busy;
            r_fill_pos <= n_fill_pos;
            r_hits     <= n_hits;
            r_misses   <= n_misses;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_misses, r_out_hits, r_out_faddr, r_out_data};
    assign m_axis_tuser  = r_out_status;

    a_no_input_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> !s_axis_tready
    ) else $error("input transfer possible during tag clear sweep");

    a_miss_starts_fill: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && (r_s1_op == OP_LOOKUP) && !r_busy && !lk_hit) |=> r_busy
    ) else $error("a miss did not start a refill");

    a_pos_idle_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_fill_pos == '0)
    ) else $error("refill position nonzero with no refill outstanding");

    a_hits_monotonic: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_hits >= $past(r_hits))
    ) else $error("hit counter decreased");

endmodule
